@@ design/bcpc_pkg.sv @@
// Shared types, constants, segment ROM and microcode program of the charge plausibility check
package bcpc_pkg;

   localparam int TABLE_ENTRIES = 6;
   localparam int ROM_ROWS      = 6;
   localparam int SCAN_ROWS     = (TABLE_ENTRIES < ROM_ROWS) ? TABLE_ENTRIES : ROM_ROWS;
   localparam int ROW_W         = $clog2(ROM_ROWS);

   localparam int CODE_W  = 12;
   localparam int WORD_W  = 16;
   localparam int MV_W    = 13;
   localparam int PCT_W   = 7;
   localparam int CNT_W   = 4;
   localparam int ALERT_W = 5;
   localparam int GRAD_W  = 7;
   localparam int ICPT_W  = 12;

   localparam int DIV_STEPS = MV_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [PCT_W-1:0]   PCT_FULL      = 7'd100;
   localparam logic [PCT_W-1:0]   TOL_RESET     = 7'd20;
   localparam logic [CNT_W-1:0]   LIMIT_RESET   = 4'd2;
   localparam logic [8:0]         KNEE_HIGH     = 9'd72;
   localparam logic [8:0]         KNEE_MID      = 9'd64;
   localparam logic [8:0]         KNEE_LOW      = 9'd35;
   localparam logic [ALERT_W-1:0] ALERT_CAP     = 5'd16;
   localparam logic [ALERT_W-1:0] ALERT_LOW     = 5'd5;
   localparam logic [5:0]         THRESH_TOP    = 6'd32;

   localparam int STEP_W = 3;

   typedef enum logic [2:0] {
      OP_WAIT    = 3'd0,
      OP_CHECK   = 3'd1,
      OP_SCAN    = 3'd2,
      OP_DIVGO   = 3'd3,
      OP_DIVWAIT = 3'd4,
      OP_UPDATE  = 3'd5,
      OP_MISS    = 3'd6,
      OP_OUT     = 3'd7
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [STEP_W-1:0] target;
   } ucode_type;

   localparam logic [STEP_W-1:0] STEP_WAIT  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CHECK = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SCAN  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_DIVGO = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DIVWT = 3'd4;
   localparam logic [STEP_W-1:0] STEP_UPD   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_MISS  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_OUT   = 3'd7;

   typedef struct packed {
      logic start;
      logic judge;
      logic hit;
      logic last_row;
      logic div_done;
      logic out_free;
   } stat_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic [MV_W-1:0]   mv;
      logic [GRAD_W-1:0] grad;
      logic [ICPT_W-1:0] icpt;
   } seg_type;

   typedef struct packed {
      logic [6:0]         pad;
      logic [ALERT_W-1:0] threshold_code;
      logic [ALERT_W-1:0] alert_pct;
      logic [CNT_W-1:0]   mismatch_count;
      logic               quickstart_request;
      logic [PCT_W-1:0]   expected_pct;
      logic [PCT_W-1:0]   reported_level;
      logic [PCT_W-1:0]   capacity_pct;
      logic [MV_W-1:0]    voltage_mv;
   } rsp_data_type;

   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type uw;
      unique case (step)
         STEP_WAIT:  uw = '{op: OP_WAIT,    target: STEP_CHECK};
         STEP_CHECK: uw = '{op: OP_CHECK,   target: STEP_OUT};
         STEP_SCAN:  uw = '{op: OP_SCAN,    target: STEP_MISS};
         STEP_DIVGO: uw = '{op: OP_DIVGO,   target: STEP_DIVWT};
         STEP_DIVWT: uw = '{op: OP_DIVWAIT, target: STEP_UPD};
         STEP_UPD:   uw = '{op: OP_UPDATE,  target: STEP_OUT};
         STEP_MISS:  uw = '{op: OP_MISS,    target: STEP_OUT};
         STEP_OUT:   uw = '{op: OP_OUT,     target: STEP_WAIT};
         default:    uw = '{op: OP_WAIT,    target: STEP_CHECK};
      endcase
      return uw;
   endfunction

   function automatic seg_type seg_rom(input logic chg, input logic [ROW_W-1:0] row);
      seg_type s;
      if (chg) begin
         case (row)
            3'd0:    s = '{mv: 13'd3865, grad: 7'd66, icpt: 12'd3709};
            3'd1:    s = '{mv: 13'd3956, grad: 7'd5,  icpt: 12'd3851};
            3'd2:    s = '{mv: 13'd4021, grad: 7'd2,  icpt: 12'd3912};
            3'd3:    s = '{mv: 13'd4088, grad: 7'd5,  icpt: 12'd3813};
            3'd4:    s = '{mv: 13'd4158, grad: 7'd7,  icpt: 12'd3689};
            3'd5:    s = '{mv: 13'd4200, grad: 7'd2,  icpt: 12'd4042};
            default: s = '{mv: 13'd3865, grad: 7'd66, icpt: 12'd3709};
         endcase
      end else begin
         case (row)
            3'd0:    s = '{mv: 13'd3953, grad: 7'd9,  icpt: 12'd3242};
            3'd1:    s = '{mv: 13'd3800, grad: 7'd7,  icpt: 12'd3403};
            3'd2:    s = '{mv: 13'd3740, grad: 7'd3,  icpt: 12'd3611};
            3'd3:    s = '{mv: 13'd3695, grad: 7'd2,  icpt: 12'd3650};
            3'd4:    s = '{mv: 13'd3601, grad: 7'd6,  icpt: 12'd3574};
            3'd5:    s = '{mv: 13'd3300, grad: 7'd55, icpt: 12'd3548};
            default: s = '{mv: 13'd3953, grad: 7'd9,  icpt: 12'd3242};
         endcase
      end
      return s;
   endfunction

endpackage

@@ design/battery_charge_plausibility_check.sv @@
// Top level: microcoded charge plausibility check with APB register port
// Steps per input transaction: wait, check, then output when judge is clear; with judge set,
// a segment scan of 1 to 6 rows, one per cycle, then miss and output when no segment
// matches, else divide start, divide wait, update and output. The divide runs in the
// bit-serial divider; the next transaction is taken in the cycle after the result is loaded.
// Synchronous reset clears the sequencer, mismatch counter, output valid and loads
// tolerance 20 and mismatch limit 2.
module battery_charge_plausibility_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // cell_voltage_code[11:0], charge_state_word[27:12]
   input  logic [1:0]  req_tuser,   // charging[0], judge[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // voltage_mv[12:0], capacity_pct[19:13],
                                    // reported_level[26:20], expected_pct[33:27],
                                    // quickstart_request[34], mismatch_count[38:35],
                                    // alert_pct[43:39], threshold_code[48:44]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int MV_W  = bcpc_pkg::MV_W;
   localparam int PCT_W = bcpc_pkg::PCT_W;
   localparam int CNT_W = bcpc_pkg::CNT_W;
   localparam int ROW_W = bcpc_pkg::ROW_W;

   bcpc_pkg::stat_type stat;
   bcpc_pkg::ctrl_type ctrl;

   logic [PCT_W-1:0]                tol_ff;
   logic [CNT_W-1:0]                lim_ff;
   logic [bcpc_pkg::CODE_W-1:0]     code_ff;
   logic [bcpc_pkg::WORD_W-1:0]     word_ff;
   logic                            chg_ff;
   logic                            judge_ff;
   logic [ROW_W-1:0]                row_ff, row_in;
   logic [PCT_W-1:0]                exp_ff, exp_in;
   logic                            qs_ff, qs_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   bcpc_pkg::rsp_data_type          rsp_data_ff, rsp_data_in;

   logic                            req_accept;
   logic                            csr_write;
   logic [MV_W+1:0]                 mv_x5;
   logic [MV_W-1:0]                 mv;
   logic [7:0]                      hi;
   logic [8:0]                      cap0, cap1, cap2, cap3, cap4;
   logic [PCT_W-1:0]                cap;
   logic [PCT_W-1:0]                level;
   logic [bcpc_pkg::ALERT_W-1:0]    alert;
   logic [bcpc_pkg::ALERT_W-1:0]    alert_min1;
   logic [5:0]                      thr_wide;
   bcpc_pkg::seg_type               seg;
   logic                            div_ok;
   logic [MV_W-1:0]                 div_dividend;
   logic [bcpc_pkg::GRAD_W-1:0]     div_divisor;
   logic                            div_start;
   logic                            div_busy;
   logic                            div_done;
   logic [MV_W-1:0]                 div_quo;
   logic [PCT_W-1:0]                exp_clamp;
   logic [PCT_W-1:0]                diff;
   logic [CNT_W:0]                  cnt_next;
   logic [CNT_W-1:0]                cnt_upd;

   assign req_tready = (ctrl.op == bcpc_pkg::OP_WAIT);
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[2] ? {{(32-CNT_W){1'b0}}, lim_ff}
                                    : {{(32-PCT_W){1'b0}}, tol_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= bcpc_pkg::TOL_RESET;
         lim_ff <= bcpc_pkg::LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2]) begin
            lim_ff <= csr_pwdata[CNT_W-1:0];
         end else begin
            tol_ff <= csr_pwdata[PCT_W-1:0];
         end
      end
   end

   // millivolts and derived percent fields
   assign mv_x5 = {1'b0, code_ff, 2'b00} + {3'b000, code_ff};
   assign mv    = mv_x5[MV_W+1:2];
   assign hi    = word_ff[15:8];
   assign cap0  = {1'b0, hi};
   assign cap1  = cap0 + {8'd0, (cap0 >= bcpc_pkg::KNEE_HIGH)};
   assign cap2  = cap1 + {8'd0, (cap1 >= bcpc_pkg::KNEE_MID)};
   assign cap3  = cap2 + {8'd0, (cap2 >= bcpc_pkg::KNEE_LOW)};
   assign cap4  = cap3 + {8'd0, word_ff[7]};
   assign cap   = (cap4 > {2'b00, bcpc_pkg::PCT_FULL}) ? bcpc_pkg::PCT_FULL : cap4[PCT_W-1:0];
   assign level = (hi > {1'b0, bcpc_pkg::PCT_FULL}) ? bcpc_pkg::PCT_FULL : hi[PCT_W-1:0];

   always_comb begin
      if (cap >= PCT_W'(bcpc_pkg::ALERT_CAP)) begin
         alert = bcpc_pkg::ALERT_CAP;
      end else if (cap <= PCT_W'(bcpc_pkg::ALERT_LOW)) begin
         alert = cap[bcpc_pkg::ALERT_W-1:0];
      end else begin
         alert = bcpc_pkg::ALERT_LOW;
      end
   end
   assign alert_min1 = (alert == '0) ? bcpc_pkg::ALERT_W'(1) : alert;
   assign thr_wide   = bcpc_pkg::THRESH_TOP - {1'b0, alert_min1};

   // segment scan and division operands
   assign seg          = bcpc_pkg::seg_rom(chg_ff, row_ff);
   assign div_ok       = (mv > {1'b0, seg.icpt}) && (seg.grad != '0);
   assign div_dividend = div_ok ? (mv - {1'b0, seg.icpt}) : '0;
   assign div_divisor  = div_ok ? seg.grad : bcpc_pkg::GRAD_W'(1);
   assign div_start    = (ctrl.op == bcpc_pkg::OP_DIVGO);

   bcpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign exp_clamp = (div_quo > MV_W'(bcpc_pkg::PCT_FULL)) ? bcpc_pkg::PCT_FULL
                                                            : div_quo[PCT_W-1:0];
   assign diff      = (exp_clamp > level) ? (exp_clamp - level) : (level - exp_clamp);
   assign cnt_next  = (diff > tol_ff) ? ({1'b0, cnt_ff} + 1'b1) : '0;
   assign cnt_upd   = (cnt_next > {1'b0, lim_ff}) ? '0 : cnt_next[CNT_W-1:0];

   assign stat.start    = req_accept;
   assign stat.judge    = judge_ff;
   assign stat.hit      = chg_ff ? (mv <= seg.mv) : (mv >= seg.mv);
   assign stat.last_row = (row_ff == ROW_W'(bcpc_pkg::SCAN_ROWS - 1));
   assign stat.div_done = div_done;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   bcpc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctrl  (ctrl)
   );

   always_comb begin
      row_in       = row_ff;
      exp_in       = exp_ff;
      qs_in        = qs_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (ctrl.op)
         bcpc_pkg::OP_WAIT: begin
            exp_in = '0;
            qs_in  = 1'b0;
         end
         bcpc_pkg::OP_CHECK: row_in = '0;
         bcpc_pkg::OP_SCAN: begin
            if (!stat.hit && !stat.last_row) begin
               row_in = row_ff + 1'b1;
            end
         end
         bcpc_pkg::OP_UPDATE: begin
            exp_in = exp_clamp;
            cnt_in = cnt_upd;
            qs_in  = (cnt_upd != '0);
         end
         bcpc_pkg::OP_MISS: begin
            qs_in = chg_ff ? (level != bcpc_pkg::PCT_FULL) : (level != '0);
         end
         bcpc_pkg::OP_OUT: begin
            if (stat.out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.pad                = '0;
               rsp_data_in.threshold_code     = thr_wide[bcpc_pkg::ALERT_W-1:0];
               rsp_data_in.alert_pct          = alert;
               rsp_data_in.mismatch_count     = cnt_ff;
               rsp_data_in.quickstart_request = qs_ff;
               rsp_data_in.expected_pct       = exp_ff;
               rsp_data_in.reported_level     = level;
               rsp_data_in.capacity_pct       = cap;
               rsp_data_in.voltage_mv         = mv;
            end
         end
         default: row_in = row_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         qs_ff        <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         qs_ff        <= qs_in;
      end
      if (req_accept) begin
         code_ff  <= req_tdata[11:0];
         word_ff  <= req_tdata[27:12];
         chg_ff   <= req_tuser[0];
         judge_ff <= req_tuser[1];
      end
      row_ff      <= row_in;
      exp_ff      <= exp_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_no_accept_while_dividing: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && div_busy))
      else $error("input taken while divider busy");

   a_qs_tracks_counter: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == bcpc_pkg::OP_UPDATE) |=> (qs_ff == (cnt_ff != '0)))
      else $error("quickstart does not follow mismatch counter");

   a_expected_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.expected_pct <= bcpc_pkg::PCT_FULL))
      else $error("expected percent above full");

   a_divide_only_on_judge: assert property (@(posedge clock) disable iff (reset)
      div_start |-> judge_ff)
      else $error("divider started for a transaction without judge");

endmodule

@@ design/bcpc_div.sv @@
// Restoring divider, one quotient bit per cycle
module bcpc_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bcpc_pkg::MV_W-1:0]    dividend,
   input  logic [bcpc_pkg::GRAD_W-1:0]  divisor,
   output logic                         busy,
   output logic                         done,
   output logic [bcpc_pkg::MV_W-1:0]    quotient
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [bcpc_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [bcpc_pkg::GRAD_W-1:0]       rem_ff, rem_in;
   logic [bcpc_pkg::MV_W-1:0]         quo_ff, quo_in;
   logic [bcpc_pkg::GRAD_W-1:0]       dsr_ff, dsr_in;
   logic [bcpc_pkg::GRAD_W:0]         trial;
   logic [bcpc_pkg::GRAD_W:0]         diff;
   logic                              fits;

   assign trial = {rem_ff, quo_ff[bcpc_pkg::MV_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = bcpc_pkg::DIV_CNT_W'(bcpc_pkg::DIV_STEPS);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[bcpc_pkg::GRAD_W-1:0] : trial[bcpc_pkg::GRAD_W-1:0];
         quo_in = {quo_ff[bcpc_pkg::MV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == bcpc_pkg::DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ design/bcpc_seq.sv @@
// Microcode sequencer: step counter, program ROM and conditional jumps
module bcpc_seq (
   input  logic                clock,
   input  logic                reset,
   input  bcpc_pkg::stat_type  stat,
   output bcpc_pkg::ctrl_type  ctrl
);

   logic [bcpc_pkg::STEP_W-1:0] step_ff, step_in;
   bcpc_pkg::ucode_type         uw;
   logic [bcpc_pkg::STEP_W-1:0] step_inc;

   assign uw       = bcpc_pkg::ucode(step_ff);
   assign step_inc = step_ff + 1'b1;

   always_comb begin
      step_in = step_ff;
      unique case (uw.op)
         bcpc_pkg::OP_WAIT:    if (stat.start) step_in = step_inc;
         bcpc_pkg::OP_CHECK:   step_in = stat.judge ? step_inc : uw.target;
         bcpc_pkg::OP_SCAN: begin
            if (stat.hit) begin
               step_in = step_inc;
            end else if (stat.last_row) begin
               step_in = uw.target;
            end
         end
         bcpc_pkg::OP_DIVGO:   step_in = step_inc;
         bcpc_pkg::OP_DIVWAIT: if (stat.div_done) step_in = step_inc;
         bcpc_pkg::OP_UPDATE:  step_in = uw.target;
         bcpc_pkg::OP_MISS:    step_in = uw.target;
         bcpc_pkg::OP_OUT:     if (stat.out_free) step_in = uw.target;
         default:              step_in = step_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= bcpc_pkg::STEP_WAIT;
      end else begin
         step_ff <= step_in;
      end
   end

   assign ctrl.op = uw.op;

endmodule
